[sv/rtnv_pkg.sv]
`timescale 1ns / 1ps
package rtnv_pkg;

  localparam int CFG_W = 12;
  localparam int CRD_W = 12;
  localparam int SUM_W = 9;
  localparam int LINE_W = 3 * SUM_W;

  localparam logic [CFG_W-1:0] RESET_HALF_WIDTH = 12'd960;
  localparam logic [CFG_W-1:0] RESET_HALF_HEIGHT = 12'd540;
  localparam logic [CFG_W-1:0] HALF_HEIGHT_LIMIT = 12'd2048;
  localparam logic [13:0] LAST_COL_RESET = 14'(2 * RESET_HALF_WIDTH - 1);
  localparam logic [CRD_W-1:0] LAST_ROW_RESET = 12'(2 * RESET_HALF_HEIGHT - 1);

  // BT.709 studio range, 0.16 fixed point
  localparam logic [15:0] K_Y_R = 16'd11966;
  localparam logic [15:0] K_Y_G = 16'd40254;
  localparam logic [15:0] K_Y_B = 16'd4064;
  localparam logic [15:0] K_CB_R = 16'd6595;
  localparam logic [15:0] K_CB_G = 16'd22187;
  localparam logic [15:0] K_CB_B = 16'd28782;
  localparam logic [15:0] K_CR_R = 16'd28782;
  localparam logic [15:0] K_CR_G = 16'd26146;
  localparam logic [15:0] K_CR_B = 16'd2639;
  // offset plus the rounding half
  localparam logic [24:0] OFFS_Y = 25'((16 << 16) + (1 << 15));
  localparam logic [24:0] OFFS_C = 25'((128 << 16) + (1 << 15));

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QLEVEL_W = 4;

  typedef enum logic [0:0] {
    REG_HALF_WIDTH  = 1'b0,
    REG_HALF_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic             is_chroma;
    logic [7:0]       luma;
    logic [7:0]       chroma_blue;
    logic [7:0]       chroma_red;
    logic [CRD_W-1:0] out_row;
    logic [CRD_W-1:0] out_column;
    logic             last_of_run;
    logic             end_of_frame;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } pair_sum_t;

  typedef struct packed {
    logic             chroma;
    logic             in_range;
    logic             eof;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] column;
  } tag_t;

  typedef struct packed {
    logic [7:0]       luma;
    logic [7:0]       cb;
    logic [7:0]       cr;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] column;
    logic             chroma;
    logic             eof;
  } entry_t;

endpackage

[sv/rtnv_ram.sv]
`timescale 1ns / 1ps
module rtnv_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rtnv_color_pipe.sv]
`timescale 1ns / 1ps
module rtnv_color_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue,
  input  rtnv_pkg::pixel_t            pix,
  input  rtnv_pkg::pair_sum_t         sums,
  input  rtnv_pkg::tag_t              tag,
  input  logic [rtnv_pkg::LINE_W-1:0] above,
  output logic                        push,
  output rtnv_pkg::entry_t            entry,
  output logic [1:0]                  inflight
);
  import rtnv_pkg::*;

  function automatic logic [7:0] round_clamp(input logic signed [25:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v[24:16] > 9'd255) begin
      r = 8'd255;
    end else begin
      r = v[23:16];
    end
    return r;
  endfunction

  logic v1, v2, v3;

  // stage 1: registered at accept, line word arrives from the RAM
  pixel_t    s1_pix;
  pair_sum_t s1_sum;
  tag_t      s1_tag;

  // stage 2: luma products and 2x2 averages
  logic [23:0] s2_yr, s2_yg, s2_yb;
  logic [7:0]  s2_ab, s2_ag, s2_ar;
  tag_t        s2_tag;

  // stage 3: luma byte and chroma products
  logic [7:0]  s3_luma;
  logic [22:0] s3_cb_r, s3_cb_g, s3_cb_b, s3_cr_r, s3_cr_g, s3_cr_b;
  tag_t        s3_tag;

  logic [LINE_W-1:0] above_m;
  logic [7:0]        avg_b, avg_g, avg_r;
  logic [24:0]       y_sum;
  logic signed [25:0] cb_v, cr_v;

  always_comb begin
    // drop a line word that lies beyond the store
    above_m = s1_tag.in_range ? above : '0;
    avg_b = 8'((10'(s1_sum.blue) + 10'(above_m[3*SUM_W-1:2*SUM_W])) >> 2);
    avg_g = 8'((10'(s1_sum.green) + 10'(above_m[2*SUM_W-1:SUM_W])) >> 2);
    avg_r = 8'((10'(s1_sum.red) + 10'(above_m[SUM_W-1:0])) >> 2);
    y_sum = 25'(s2_yr) + 25'(s2_yg) + 25'(s2_yb) + OFFS_Y;
    cb_v = signed'(26'(OFFS_C) + 26'(s3_cb_b) - 26'(s3_cb_r) - 26'(s3_cb_g));
    cr_v = signed'(26'(OFFS_C) + 26'(s3_cr_r) - 26'(s3_cr_g) - 26'(s3_cr_b));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix <= pix;
    s1_sum <= sums;
    s1_tag <= tag;

    s2_yr  <= 24'(K_Y_R) * 24'(s1_pix.red);
    s2_yg  <= 24'(K_Y_G) * 24'(s1_pix.green);
    s2_yb  <= 24'(K_Y_B) * 24'(s1_pix.blue);
    s2_ab  <= avg_b;
    s2_ag  <= avg_g;
    s2_ar  <= avg_r;
    s2_tag <= s1_tag;

    s3_luma <= round_clamp(signed'(26'(y_sum)));
    s3_cb_r <= 23'(24'(K_CB_R) * 24'(s2_ar));
    s3_cb_g <= 23'(24'(K_CB_G) * 24'(s2_ag));
    s3_cb_b <= 23'(24'(K_CB_B) * 24'(s2_ab));
    s3_cr_r <= 23'(24'(K_CR_R) * 24'(s2_ar));
    s3_cr_g <= 23'(24'(K_CR_G) * 24'(s2_ag));
    s3_cr_b <= 23'(24'(K_CR_B) * 24'(s2_ab));
    s3_tag  <= s2_tag;
  end

  always_comb begin
    push = v3;
    entry.luma = s3_luma;
    entry.cb = round_clamp(cb_v);
    entry.cr = round_clamp(cr_v);
    entry.row = s3_tag.row;
    entry.column = s3_tag.column;
    entry.chroma = s3_tag.chroma;
    entry.eof = s3_tag.eof;
    inflight = 2'(v1) + 2'(v2) + 2'(v3);
  end

endmodule

[sv/rtnv_result_queue.sv]
`timescale 1ns / 1ps
module rtnv_result_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  rtnv_pkg::entry_t              entry,
  output logic                          result_valid,
  input  logic                          result_ready,
  output rtnv_pkg::result_t             result,
  output logic [rtnv_pkg::QLEVEL_W-1:0] fill
);
  import rtnv_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QLEVEL_W-1:0] level;
  logic                chroma_phase;
  entry_t              head;
  logic                take, pop;

  always_comb begin
    head = slots[rd_ptr];
    result_valid = (level != '0);
    take = result_valid & result_ready;
    // a pixel with a chroma word leaves after its second word
    pop = take & (chroma_phase | ~head.chroma);
    fill = level;

    result.is_chroma = chroma_phase;
    result.luma = chroma_phase ? 8'd0 : head.luma;
    result.chroma_blue = chroma_phase ? head.cb : 8'd0;
    result.chroma_red = chroma_phase ? head.cr : 8'd0;
    result.out_row = chroma_phase ? (head.row >> 1) : head.row;
    result.out_column = chroma_phase ? (head.column >> 1) : head.column;
    result.last_of_run = chroma_phase | ~head.chroma;
    result.end_of_frame = head.eof;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
      chroma_phase <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
        chroma_phase <= 1'b0;
      end else if (take) begin
        chroma_phase <= 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

[sv/rgb_to_nv12_bt709_converter.sv]
`timescale 1ns / 1ps
// RGB to NV12 (BT.709 studio range) converter.
// Pixel channel: pixel_valid / pixel_ready with one BGR pixel per word, in
// raster order. Result channel: result_valid / result_ready; every pixel gives
// a luma word, and the pixel that closes a 2x2 block (odd row, odd column)
// gives a chroma word right after its luma word, flagged by is_chroma.
// Frame size comes from cfg_write / cfg_index / cfg_data in pixel pairs;
// write it only while the block is idle.
// Each pixel passes three math stages, then the result queue, before its
// luma word can be taken.
// Throughput: one pixel per cycle while the receiver keeps up; the result
// port moves one word per cycle, so on odd rows a pixel that closes a block
// holds the result port for both its words.
// pixel_ready follows the free room of an eight-entry result queue minus the
// pixels still in the math stages, so a stalled receiver backs the source
// up after at most eight pixels. The line store of horizontal pair sums is a
// single RAM of MAX_HALF_WIDTH words, written on even rows and read one
// row later; it needs no clearing.
// Reset (synchronous) empties the queue, restores 1920x1080 (width clamped to
// the line store) and moves the position to the top left pixel.
module rgb_to_nv12_bt709_converter #(
  parameter int MAX_HALF_WIDTH = 2048
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pixel_valid,
  output logic                       pixel_ready,
  input  rtnv_pkg::pixel_t           pixel,
  output logic                       result_valid,
  input  logic                       result_ready,
  output rtnv_pkg::result_t          result,
  input  logic                       cfg_write,
  input  rtnv_pkg::cfg_reg_t         cfg_index,
  input  logic [rtnv_pkg::CFG_W-1:0] cfg_data
);
  import rtnv_pkg::*;

  localparam int ADDR_W = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
  // reset width clamped to the line store like any written width
  localparam logic [13:0] LAST_COL_AT_RESET =
    (MAX_HALF_WIDTH < int'(RESET_HALF_WIDTH)) ? 14'(2 * MAX_HALF_WIDTH - 1)
                                              : LAST_COL_RESET;

  logic [13:0]      last_col;
  logic [CRD_W-1:0] last_row;
  logic [CRD_W-1:0] column_count, row_count;
  pixel_t           first_of_pair;

  logic [CFG_W-1:0] hw_nz, ht_nz, ht_eff;
  logic [14:0]      hw_eff;
  logic [13:0]      col_limit;
  logic [CRD_W-1:0] row_limit;

  logic              accept, row_end, frame_end, odd_col, odd_row;
  logic [CRD_W-2:0]  idx;
  logic              in_range, line_we, chroma_req;
  logic [ADDR_W-1:0] line_addr;
  pair_sum_t         sums;
  tag_t              tag;
  logic [LINE_W-1:0] line_rdata;

  logic                push;
  entry_t              entry;
  logic [1:0]          inflight;
  logic [QLEVEL_W-1:0] fill;
  logic [QLEVEL_W:0]   claimed;

  // size registers hold the last column and row, already clamped
  always_comb begin
    hw_nz = (cfg_data == '0) ? CFG_W'(1) : cfg_data;
    hw_eff = 15'(hw_nz);
    if (32'(hw_nz) > MAX_HALF_WIDTH) begin
      hw_eff = 15'(MAX_HALF_WIDTH);
    end
    col_limit = 14'({hw_eff, 1'b0} - 16'd1);
    ht_nz = (cfg_data == '0) ? CFG_W'(1) : cfg_data;
    ht_eff = (ht_nz > HALF_HEIGHT_LIMIT) ? HALF_HEIGHT_LIMIT : ht_nz;
    row_limit = CRD_W'({ht_eff, 1'b0} - 13'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= LAST_COL_AT_RESET;
      last_row <= LAST_ROW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HALF_WIDTH:  last_col <= col_limit;
        REG_HALF_HEIGHT: last_row <= row_limit;
      endcase
    end
  end

  always_comb begin
    claimed = (QLEVEL_W + 1)'(fill) + (QLEVEL_W + 1)'(inflight);
    pixel_ready = (claimed < (QLEVEL_W + 1)'(QUEUE_DEPTH));
    accept = pixel_valid & pixel_ready;

    row_end = ({2'b00, column_count} >= last_col);
    frame_end = row_end & (row_count >= last_row);
    odd_col = column_count[0];
    odd_row = row_count[0];
    idx = column_count[CRD_W-1:1];
    in_range = (32'(idx) < MAX_HALF_WIDTH);
    line_addr = ADDR_W'(idx);

    sums.blue = SUM_W'(pixel.blue) + SUM_W'(first_of_pair.blue);
    sums.green = SUM_W'(pixel.green) + SUM_W'(first_of_pair.green);
    sums.red = SUM_W'(pixel.red) + SUM_W'(first_of_pair.red);

    // even row stores the pair sum, odd row fetches it for the block
    line_we = accept & odd_col & ~odd_row & in_range;
    chroma_req = accept & odd_col & odd_row;

    tag.chroma = odd_col & odd_row;
    tag.in_range = in_range;
    tag.eof = frame_end;
    tag.row = row_count;
    tag.column = column_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      first_of_pair <= '0;
    end else if (accept) begin
      if (!odd_col) begin
        first_of_pair <= pixel;
      end
      if (row_end) begin
        column_count <= '0;
        row_count <= frame_end ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  rtnv_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_HALF_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (line_we),
    .waddr(line_addr),
    .wdata(sums),
    .raddr(line_addr),
    .rdata(line_rdata)
  );

  rtnv_color_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .issue   (accept),
    .pix     (pixel),
    .sums    (sums),
    .tag     (tag),
    .above   (line_rdata),
    .push    (push),
    .entry   (entry),
    .inflight(inflight)
  );

  rtnv_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .entry       (entry),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .fill        (fill)
  );

`ifndef SYNTHESIS
  a_no_overcommit: assert property (@(posedge clk) disable iff (rst)
    claimed <= (QLEVEL_W + 1)'(QUEUE_DEPTH))
    else $error("result queue overcommitted");

  a_line_port: assert property (@(posedge clk) disable iff (rst)
    !(line_we && chroma_req))
    else $error("line store written and fetched by one pixel");

  a_chroma_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !result.last_of_run) |=>
      (result_valid && result.is_chroma))
    else $error("chroma word missing after luma word");
`endif

endmodule
